// File: hdl/latest_frame_mailbox_assert.svh
// Assertion macros for the latest-frame mailbox (clock i_clk, sync reset i_rst_n)
`ifndef LATEST_FRAME_MAILBOX_ASSERT_SVH
`define LATEST_FRAME_MAILBOX_ASSERT_SVH
`ifndef NO_ASSERTIONS
// property checked on every clock outside reset
`define LFM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// condition that must never be true outside reset
`define LFM_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);
`else
`define LFM_ASSERT(label, prop, msg)
`define LFM_NEVER(label, cond, msg)
`endif
`endif

// File: hdl/lfm_pkg.sv
// Shared types and constants for the latest-frame mailbox
package lfm_pkg;

    // Stored frame identifier width and event counter width
    localparam int FRAME_ID_BITS = 16;
    localparam int COUNT_BITS    = 32;

    // Port field widths
    localparam int OPCODE_BITS      = 2;
    localparam int FRAME_FIELD_BITS = 16;
    localparam int COUNT_FIELD_BITS = 32;

    typedef logic [FRAME_ID_BITS-1:0]    t_frame;
    typedef logic [COUNT_BITS-1:0]       t_count;
    typedef logic [FRAME_FIELD_BITS-1:0] t_frame_field;
    typedef logic [COUNT_FIELD_BITS-1:0] t_count_field;

    typedef enum logic [OPCODE_BITS-1:0] {
        OP_OFFER    = 2'd0,
        OP_BEGIN    = 2'd1,
        OP_COMPLETE = 2'd2,
        OP_CANCEL   = 2'd3
    } t_opcode;

    // Output register occupancy
    typedef enum logic {
        CTL_EMPTY,
        CTL_FULL
    } t_ctl_state;

    // Controller to datapath command
    typedef struct packed {
        logic step;
    } t_dp_cmd;

    // Controller status toward the top level
    typedef struct packed {
        logic in_ready;
        logic out_valid;
    } t_ctl_status;

    // One result transaction
    typedef struct packed {
        logic         has_frame;
        t_frame_field frame_out;
        logic         busy_now;
        logic         begun_now;
        logic         waiting_now;
        t_count_field offers_seen;
        t_count_field immediates_seen;
        t_count_field submits_seen;
        t_count_field stores_seen;
        t_count_field replacements_seen;
        t_count_field completions_seen;
    } t_result;

endpackage

// File: hdl/lfm_if.sv
// Valid/ready channel interfaces for the mailbox input and result streams
interface lfm_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [lfm_pkg::OPCODE_BITS-1:0]      opcode;
    logic [lfm_pkg::FRAME_FIELD_BITS-1:0] frame_in;

    modport source (output valid, output opcode, output frame_in, input ready);
    modport sink   (input valid, input opcode, input frame_in, output ready);
endinterface

interface lfm_out_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 has_frame;
    logic [lfm_pkg::FRAME_FIELD_BITS-1:0] frame_out;
    logic                                 busy_now;
    logic                                 begun_now;
    logic                                 waiting_now;
    logic [lfm_pkg::COUNT_FIELD_BITS-1:0] offers_seen;
    logic [lfm_pkg::COUNT_FIELD_BITS-1:0] immediates_seen;
    logic [lfm_pkg::COUNT_FIELD_BITS-1:0] submits_seen;
    logic [lfm_pkg::COUNT_FIELD_BITS-1:0] stores_seen;
    logic [lfm_pkg::COUNT_FIELD_BITS-1:0] replacements_seen;
    logic [lfm_pkg::COUNT_FIELD_BITS-1:0] completions_seen;

    modport source (
        output valid, output has_frame, output frame_out, output busy_now,
        output begun_now, output waiting_now, output offers_seen,
        output immediates_seen, output submits_seen, output stores_seen,
        output replacements_seen, output completions_seen, input ready
    );
    modport sink (
        input valid, input has_frame, input frame_out, input busy_now,
        input begun_now, input waiting_now, input offers_seen,
        input immediates_seen, input submits_seen, input stores_seen,
        input replacements_seen, input completions_seen, output ready
    );
endinterface

// File: hdl/lfm_ctrl.sv
// Handshake controller: tracks the result register and issues step commands
module lfm_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_out_ready,
    output lfm_pkg::t_dp_cmd     o_cmd,
    output lfm_pkg::t_ctl_status o_status
);

    lfm_pkg::t_ctl_state r_state;
    lfm_pkg::t_ctl_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lfm_pkg::CTL_EMPTY;
        end else begin
            r_state <= n_state;
        end
    end

    // Accept when the result register is empty or being drained this cycle
    always_comb begin
        n_state            = r_state;
        o_status.in_ready  = 1'b0;
        o_status.out_valid = 1'b0;
        o_cmd.step         = 1'b0;
        unique case (r_state)
            lfm_pkg::CTL_EMPTY: begin
                o_status.in_ready = 1'b1;
                o_cmd.step        = i_in_valid;
                if (i_in_valid) begin
                    n_state = lfm_pkg::CTL_FULL;
                end
            end
            lfm_pkg::CTL_FULL: begin
                o_status.out_valid = 1'b1;
                o_status.in_ready  = i_out_ready;
                o_cmd.step         = i_out_ready && i_in_valid;
                if (i_out_ready && !i_in_valid) begin
                    n_state = lfm_pkg::CTL_EMPTY;
                end
            end
        endcase
    end

endmodule

// File: hdl/lfm_datapath.sv
// Mailbox slots, saturating event counters and returned-frame register
module lfm_datapath (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  lfm_pkg::t_dp_cmd                     i_cmd,
    input  logic [lfm_pkg::OPCODE_BITS-1:0]      i_opcode,
    input  logic [lfm_pkg::FRAME_FIELD_BITS-1:0] i_frame_in,
    output lfm_pkg::t_result                     o_result
);

    // Saturating increment
    function automatic lfm_pkg::t_count sat_inc(input lfm_pkg::t_count c);
        return (&c) ? c : c + lfm_pkg::t_count'(1);
    endfunction

    logic                  r_cur_valid, n_cur_valid;
    logic                  r_cur_begun, n_cur_begun;
    logic                  r_wait_valid, n_wait_valid;
    lfm_pkg::t_frame       r_cur_frame, n_cur_frame;
    lfm_pkg::t_frame       r_wait_frame, n_wait_frame;
    lfm_pkg::t_count       r_offers, n_offers;
    lfm_pkg::t_count       r_immediates, n_immediates;
    lfm_pkg::t_count       r_submits, n_submits;
    lfm_pkg::t_count       r_stores, n_stores;
    lfm_pkg::t_count       r_replacements, n_replacements;
    lfm_pkg::t_count       r_completions, n_completions;
    logic                  r_has_frame, n_has_frame;
    lfm_pkg::t_frame_field r_frame_out, n_frame_out;
    lfm_pkg::t_frame       w_frame;

    // Next state for one transaction
    always_comb begin
        w_frame        = lfm_pkg::t_frame'(i_frame_in);
        n_cur_valid    = r_cur_valid;
        n_cur_begun    = r_cur_begun;
        n_wait_valid   = r_wait_valid;
        n_cur_frame    = r_cur_frame;
        n_wait_frame   = r_wait_frame;
        n_offers       = r_offers;
        n_immediates   = r_immediates;
        n_submits      = r_submits;
        n_stores       = r_stores;
        n_replacements = r_replacements;
        n_completions  = r_completions;
        n_has_frame    = 1'b0;
        n_frame_out    = '0;
        unique case (lfm_pkg::t_opcode'(i_opcode))
            lfm_pkg::OP_OFFER: begin
                n_offers = sat_inc(r_offers);
                if (!r_cur_valid) begin
                    n_cur_valid  = 1'b1;
                    n_cur_frame  = w_frame;
                    n_cur_begun  = 1'b0;
                    n_immediates = sat_inc(r_immediates);
                    n_submits    = sat_inc(r_submits);
                end else if (r_wait_valid) begin
                    // latest wins: hand back the older pending frame
                    n_has_frame    = 1'b1;
                    n_frame_out    = lfm_pkg::t_frame_field'(r_wait_frame);
                    n_replacements = sat_inc(r_replacements);
                    n_wait_frame   = w_frame;
                end else begin
                    n_stores     = sat_inc(r_stores);
                    n_wait_valid = 1'b1;
                    n_wait_frame = w_frame;
                end
            end
            lfm_pkg::OP_BEGIN: begin
                if (r_cur_valid && !r_cur_begun) begin
                    n_cur_begun = 1'b1;
                    n_has_frame = 1'b1;
                    n_frame_out = lfm_pkg::t_frame_field'(r_cur_frame);
                end
            end
            lfm_pkg::OP_COMPLETE: begin
                if (r_cur_valid && r_cur_begun) begin
                    // retire and promote the pending frame
                    n_has_frame   = 1'b1;
                    n_frame_out   = lfm_pkg::t_frame_field'(r_cur_frame);
                    n_completions = sat_inc(r_completions);
                    n_cur_begun   = 1'b0;
                    n_cur_valid   = r_wait_valid;
                    n_cur_frame   = r_wait_valid ? r_wait_frame : '0;
                    n_wait_valid  = 1'b0;
                    n_wait_frame  = '0;
                    if (r_wait_valid) begin
                        n_submits = sat_inc(r_submits);
                    end
                end
            end
            lfm_pkg::OP_CANCEL: begin
                if (r_wait_valid) begin
                    n_has_frame = 1'b1;
                    n_frame_out = lfm_pkg::t_frame_field'(r_wait_frame);
                end
                n_wait_valid = 1'b0;
                n_wait_frame = '0;
            end
        endcase
    end

    // Control flags and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid    <= 1'b0;
            r_cur_begun    <= 1'b0;
            r_wait_valid   <= 1'b0;
            r_offers       <= '0;
            r_immediates   <= '0;
            r_submits      <= '0;
            r_stores       <= '0;
            r_replacements <= '0;
            r_completions  <= '0;
        end else if (i_cmd.step) begin
            r_cur_valid    <= n_cur_valid;
            r_cur_begun    <= n_cur_begun;
            r_wait_valid   <= n_wait_valid;
            r_offers       <= n_offers;
            r_immediates   <= n_immediates;
            r_submits      <= n_submits;
            r_stores       <= n_stores;
            r_replacements <= n_replacements;
            r_completions  <= n_completions;
        end
    end

    // Frame slots and returned frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_frame  <= '0;
            r_wait_frame <= '0;
            r_has_frame  <= 1'b0;
            r_frame_out  <= '0;
        end else if (i_cmd.step) begin
            r_cur_frame  <= n_cur_frame;
            r_wait_frame <= n_wait_frame;
            r_has_frame  <= n_has_frame;
            r_frame_out  <= n_frame_out;
        end
    end

    // Result: state only moves on a step, so it mirrors the last transaction
    always_comb begin
        o_result.has_frame         = r_has_frame;
        o_result.frame_out         = r_frame_out;
        o_result.busy_now          = r_cur_valid;
        o_result.begun_now         = r_cur_begun;
        o_result.waiting_now       = r_wait_valid;
        o_result.offers_seen       = lfm_pkg::t_count_field'(r_offers);
        o_result.immediates_seen   = lfm_pkg::t_count_field'(r_immediates);
        o_result.submits_seen      = lfm_pkg::t_count_field'(r_submits);
        o_result.stores_seen       = lfm_pkg::t_count_field'(r_stores);
        o_result.replacements_seen = lfm_pkg::t_count_field'(r_replacements);
        o_result.completions_seen  = lfm_pkg::t_count_field'(r_completions);
    end

endmodule

// File: hdl/latest_frame_mailbox.sv
// Latest-wins frame mailbox: one in-flight slot, one pending slot
//
// Input channel i_in carries one command per transaction: opcode (offer,
// begin, complete, cancel pending) and frame_in, used by offer only.
// Output channel o_out returns one result per command: the returned frame
// (if any), the slot occupancy after the command and six saturating
// event counters.
// Latency: a result is valid the cycle after its command is accepted.
// Throughput: one command per cycle while the receiver takes results; the
// single result register is the only stage, reloaded in the same cycle it is drained.
// When the receiver stalls, the result holds and i_in.ready drops until
// the result is taken; no command is lost or reordered.
// Reset (synchronous, active low) empties both slots, clears all counters
// and the result register; i_in.ready is high in the first cycle after.
`include "latest_frame_mailbox_assert.svh"

module latest_frame_mailbox (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lfm_in_if.sink     i_in,
    lfm_out_if.source  o_out
);

    lfm_pkg::t_dp_cmd     w_cmd;
    lfm_pkg::t_ctl_status w_status;
    lfm_pkg::t_result     w_result;

    // Handshake control
    lfm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (w_cmd),
        .o_status    (w_status)
    );

    // Slots and counters
    lfm_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_opcode   (i_in.opcode),
        .i_frame_in (i_in.frame_in),
        .o_result   (w_result)
    );

    // Channel wiring
    assign i_in.ready              = w_status.in_ready;
    assign o_out.valid             = w_status.out_valid;
    assign o_out.has_frame         = w_result.has_frame;
    assign o_out.frame_out         = w_result.frame_out;
    assign o_out.busy_now          = w_result.busy_now;
    assign o_out.begun_now         = w_result.begun_now;
    assign o_out.waiting_now       = w_result.waiting_now;
    assign o_out.offers_seen       = w_result.offers_seen;
    assign o_out.immediates_seen   = w_result.immediates_seen;
    assign o_out.submits_seen      = w_result.submits_seen;
    assign o_out.stores_seen       = w_result.stores_seen;
    assign o_out.replacements_seen = w_result.replacements_seen;
    assign o_out.completions_seen  = w_result.completions_seen;

    // Checks
    `LFM_ASSERT(a_accept_gives_result, (i_in.valid && i_in.ready) |=> o_out.valid, "accepted transaction produced no result")
    `LFM_NEVER(a_begun_needs_busy, o_out.valid && o_out.begun_now && !o_out.busy_now, "begun without in-flight frame")
    `LFM_NEVER(a_wait_needs_busy, o_out.valid && o_out.waiting_now && !o_out.busy_now, "pending frame while in-flight slot empty")
    `LFM_ASSERT(a_stall_holds_result, (o_out.valid && !o_out.ready) |=> (o_out.valid && $stable(o_out.frame_out) && $stable(o_out.has_frame)), "stalled result changed")

endmodule

// File: verif/testbench.sv
// Self-checking testbench for the latest-frame mailbox
`timescale 1ns / 1ps

module testbench;

    // Tracks mailbox state and holds the results still owed by the block
    class mailbox_book;
        logic                  cur_valid;
        logic                  cur_begun;
        lfm_pkg::t_frame       cur_frame;
        logic                  wait_valid;
        lfm_pkg::t_frame       wait_frame;
        lfm_pkg::t_count       offers;
        lfm_pkg::t_count       immediates;
        lfm_pkg::t_count       submits;
        lfm_pkg::t_count       stores;
        lfm_pkg::t_count       replacements;
        lfm_pkg::t_count       completions;
        lfm_pkg::t_result      owed_q[$];
        int unsigned           mismatches;

        function new();
            cur_valid    = 1'b0;
            cur_begun    = 1'b0;
            cur_frame    = '0;
            wait_valid   = 1'b0;
            wait_frame   = '0;
            offers       = '0;
            immediates   = '0;
            submits      = '0;
            stores       = '0;
            replacements = '0;
            completions  = '0;
            mismatches   = 0;
        endfunction

        // Counters stick at all ones
        function lfm_pkg::t_count sat_inc(lfm_pkg::t_count c);
            return (c == '1) ? c : c + 1'b1;
        endfunction

        // Apply one accepted command and queue the result it must produce
        function void note_command(lfm_pkg::t_opcode op, lfm_pkg::t_frame_field frame_in);
            lfm_pkg::t_result r;
            lfm_pkg::t_frame  fr;
            r  = '0;
            fr = lfm_pkg::t_frame'(frame_in);
            case (op)
                lfm_pkg::OP_OFFER: begin
                    offers = sat_inc(offers);
                    if (!cur_valid) begin
                        cur_valid  = 1'b1;
                        cur_frame  = fr;
                        cur_begun  = 1'b0;
                        immediates = sat_inc(immediates);
                        submits    = sat_inc(submits);
                    end else if (wait_valid) begin
                        // newest offer wins, older pending frame is handed back
                        r.has_frame  = 1'b1;
                        r.frame_out  = lfm_pkg::t_frame_field'(wait_frame);
                        replacements = sat_inc(replacements);
                        wait_frame   = fr;
                    end else begin
                        stores     = sat_inc(stores);
                        wait_valid = 1'b1;
                        wait_frame = fr;
                    end
                end
                lfm_pkg::OP_BEGIN: begin
                    if (cur_valid && !cur_begun) begin
                        cur_begun   = 1'b1;
                        r.has_frame = 1'b1;
                        r.frame_out = lfm_pkg::t_frame_field'(cur_frame);
                    end
                end
                lfm_pkg::OP_COMPLETE: begin
                    if (cur_valid && cur_begun) begin
                        r.has_frame = 1'b1;
                        r.frame_out = lfm_pkg::t_frame_field'(cur_frame);
                        completions = sat_inc(completions);
                        // promote the pending frame, if any
                        cur_begun  = 1'b0;
                        cur_valid  = wait_valid;
                        cur_frame  = wait_valid ? wait_frame : '0;
                        wait_valid = 1'b0;
                        wait_frame = '0;
                        if (cur_valid)
                            submits = sat_inc(submits);
                    end
                end
                default: begin
                    if (wait_valid) begin
                        r.has_frame = 1'b1;
                        r.frame_out = lfm_pkg::t_frame_field'(wait_frame);
                    end
                    wait_valid = 1'b0;
                    wait_frame = '0;
                end
            endcase
            r.busy_now          = cur_valid;
            r.begun_now         = cur_begun;
            r.waiting_now       = wait_valid;
            r.offers_seen       = lfm_pkg::t_count_field'(offers);
            r.immediates_seen   = lfm_pkg::t_count_field'(immediates);
            r.submits_seen      = lfm_pkg::t_count_field'(submits);
            r.stores_seen       = lfm_pkg::t_count_field'(stores);
            r.replacements_seen = lfm_pkg::t_count_field'(replacements);
            r.completions_seen  = lfm_pkg::t_count_field'(completions);
            owed_q.push_back(r);
        endfunction

        task report(string msg);
            mismatches++;
            $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task compare(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want)
                report($sformatf("%s expected %0h got %0h", field, want, got));
        endtask

        // Compare one result transaction with the oldest owed result
        task check_result(lfm_pkg::t_result got);
            lfm_pkg::t_result want;
            if (owed_q.size() == 0) begin
                report($sformatf("result with nothing outstanding (frame_out %0h)",
                                 got.frame_out));
                return;
            end
            want = owed_q.pop_front();
            compare("has_frame", want.has_frame, got.has_frame);
            compare("frame_out", want.frame_out, got.frame_out);
            compare("busy_now", want.busy_now, got.busy_now);
            compare("begun_now", want.begun_now, got.begun_now);
            compare("waiting_now", want.waiting_now, got.waiting_now);
            compare("offers_seen", want.offers_seen, got.offers_seen);
            compare("immediates_seen", want.immediates_seen, got.immediates_seen);
            compare("submits_seen", want.submits_seen, got.submits_seen);
            compare("stores_seen", want.stores_seen, got.stores_seen);
            compare("replacements_seen", want.replacements_seen,
                    got.replacements_seen);
            compare("completions_seen", want.completions_seen, got.completions_seen);
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    lfm_in_if  in_if();
    lfm_out_if out_if();

    latest_frame_mailbox dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if.sink),
        .o_out   (out_if.source)
    );

    mailbox_book book = new();
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    // Clock, 8 ns period
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Receiver: random stalls on the result channel
    always @(posedge i_clk) begin
        out_if.ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: check every result transaction
    always @(posedge i_clk) begin : result_mon
        lfm_pkg::t_result got;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got.has_frame         = out_if.has_frame;
            got.frame_out         = out_if.frame_out;
            got.busy_now          = out_if.busy_now;
            got.begun_now         = out_if.begun_now;
            got.waiting_now       = out_if.waiting_now;
            got.offers_seen       = out_if.offers_seen;
            got.immediates_seen   = out_if.immediates_seen;
            got.submits_seen      = out_if.submits_seen;
            got.stores_seen       = out_if.stores_seen;
            got.replacements_seen = out_if.replacements_seen;
            got.completions_seen  = out_if.completions_seen;
            book.check_result(got);
        end
    end

    // One command transaction; valid stays up after acceptance so the
    // next call either reloads it or drops it, never both in one step
    task automatic send_cmd(lfm_pkg::t_opcode op, lfm_pkg::t_frame_field frame);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid    <= 1'b1;
        in_if.opcode   <= op;
        in_if.frame_in <= frame;
        @(posedge i_clk);
        while (!in_if.ready)
            @(posedge i_clk);
        book.note_command(op, frame);
    endtask

    // Hold off the sender until every owed result has come back
    task automatic drain();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (book.owed_q.size() != 0)
            @(posedge i_clk);
    endtask

    // Random command mix: offers dominate, begin/complete keep frames moving
    task automatic run_random(int unsigned count);
        int unsigned           pick;
        lfm_pkg::t_opcode      op;
        lfm_pkg::t_frame_field frame;
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 40)
                op = lfm_pkg::OP_OFFER;
            else if (pick < 65)
                op = lfm_pkg::OP_BEGIN;
            else if (pick < 90)
                op = lfm_pkg::OP_COMPLETE;
            else
                op = lfm_pkg::OP_CANCEL;
            case ($urandom_range(7))
                0:       frame = '0;
                1:       frame = '1;
                default: frame = lfm_pkg::t_frame_field'($urandom);
            endcase
            send_cmd(op, frame);
        end
    endtask

    // Stimulus
    initial begin
        i_rst_n         <= 1'b0;
        in_if.valid     <= 1'b0;
        in_if.opcode    <= lfm_pkg::OP_OFFER;
        in_if.frame_in  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty mailbox, extremes of frame ids, each slot transition
        send_cmd(lfm_pkg::OP_CANCEL, 16'h1234);   // nothing pending
        send_cmd(lfm_pkg::OP_BEGIN, 16'h1234);    // nothing in flight
        send_cmd(lfm_pkg::OP_COMPLETE, 16'h1234); // nothing started
        send_cmd(lfm_pkg::OP_OFFER, 16'h0000);    // straight into flight
        send_cmd(lfm_pkg::OP_OFFER, 16'hFFFF);    // stored as pending
        send_cmd(lfm_pkg::OP_OFFER, 16'h8001);    // replaces pending, returns FFFF
        send_cmd(lfm_pkg::OP_COMPLETE, 16'h0000); // in flight but not started
        send_cmd(lfm_pkg::OP_BEGIN, 16'h0000);
        send_cmd(lfm_pkg::OP_BEGIN, 16'h0000);    // already started
        send_cmd(lfm_pkg::OP_OFFER, 16'h7FFE);    // replace again
        send_cmd(lfm_pkg::OP_COMPLETE, 16'h0000); // retires 0, promotes 7FFE
        send_cmd(lfm_pkg::OP_BEGIN, 16'hFFFF);
        send_cmd(lfm_pkg::OP_OFFER, 16'h5555);
        send_cmd(lfm_pkg::OP_CANCEL, 16'h0000);   // returns 5555
        send_cmd(lfm_pkg::OP_CANCEL, 16'h0000);   // nothing left to cancel
        send_cmd(lfm_pkg::OP_OFFER, 16'hAAAA);
        send_cmd(lfm_pkg::OP_COMPLETE, 16'h0000); // promotes AAAA
        send_cmd(lfm_pkg::OP_COMPLETE, 16'h0000); // promoted frame not started yet
        send_cmd(lfm_pkg::OP_BEGIN, 16'h0000);
        send_cmd(lfm_pkg::OP_COMPLETE, 16'h0000); // nothing to promote
        send_cmd(lfm_pkg::OP_OFFER, 16'hFFFF);
        drain();

        // Random phases with different idle patterns on each side
        run_random(175);
        drain();
        send_idle_pct = 70;
        run_random(175);
        drain();
        send_idle_pct  = 0;
        recv_stall_pct = 70;
        run_random(175);
        drain();
        send_idle_pct  = 19;
        recv_stall_pct = 19;
        run_random(175);
        drain();

        repeat (8) @(posedge i_clk);
        if (book.owed_q.size() != 0)
            book.report($sformatf("%0d results never arrived", book.owed_q.size()));
        if (book.mismatches == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("testbench: FAIL");
        $finish;
    end

endmodule
